// ===== rtl/mlm_pkg.sv =====
package mlm_pkg;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic keep;
    logic last;
  } item_tag_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/mlm_front.sv =====
module mlm_front import mlm_pkg::*; #(
  parameter int NUM_LIMBS = 16,
  parameter int LIMB_BITS = 8,
  localparam int IW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1,
  localparam int CW = $clog2(NUM_LIMBS + 1),
  localparam int QW = 2 * LIMB_BITS + IW + $bits(item_tag_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [LIMB_BITS-1:0] a_limb,
  input  logic [LIMB_BITS-1:0] b_limb,
  input  logic                 last_in,
  output logic [QW-1:0]        qdata
);

  logic [CW-1:0] count;
  item_tag_t     tag;
  logic [IW-1:0] idx;

  // pairs past the store depth are still queued so a late last closes the operands
  assign tag.keep = count < CW'(NUM_LIMBS);
  assign tag.last = last_in;
  assign idx      = count[IW-1:0];
  assign qdata    = {a_limb, b_limb, idx, tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (last_in) begin
        count <= '0;
      end else if (tag.keep) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

// ===== rtl/mlm_queue.sv =====
module mlm_queue import mlm_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output q_status_t    status
);

  logic [W-1:0]       mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] cnt;

  assign status.full  = cnt == Q_CNT_W'(Q_DEPTH);
  assign status.empty = cnt == '0;
  assign dout         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mlm_back.sv =====
module mlm_back import mlm_pkg::*; #(
  parameter int NUM_LIMBS = 16,
  parameter int LIMB_BITS = 8,
  localparam int IW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1,
  localparam int CW = $clog2(NUM_LIMBS + 1),
  localparam int TW = $bits(item_tag_t),
  localparam int QW = 2 * LIMB_BITS + IW + TW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [QW-1:0]        qdata,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 strobe,
  output logic [LIMB_BITS-1:0] product_limb,
  output logic                 last_out
);

  localparam int H  = (LIMB_BITS + 1) / 2;
  localparam int AW = 2 * LIMB_BITS + 6;
  localparam int KW = $clog2(2 * NUM_LIMBS);
  localparam logic [KW-1:0] TOP = KW'(2 * NUM_LIMBS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [LIMB_BITS-1:0] a_mem [NUM_LIMBS];
  logic [LIMB_BITS-1:0] b_mem [NUM_LIMBS];
  logic [CW-1:0]        fill;

  logic [1:0]    state;
  logic [KW-1:0] k;
  logic [IW-1:0] i;
  logic [1:0]    part;
  logic [2*H-1:0] pp;
  logic [1:0]    pp_sh;
  logic          pp_valid;
  logic [AW-1:0] acc;
  logic [AW-1:0] pp_ext;

  item_tag_t            tag;
  logic [IW-1:0]        idx;
  logic [LIMB_BITS-1:0] qa;
  logic [LIMB_BITS-1:0] qb;

  logic [KW-1:0]        j;
  logic                 a_ok;
  logic                 b_ok;
  logic [LIMB_BITS-1:0] a_op;
  logic [LIMB_BITS-1:0] b_op;
  logic [H-1:0]         x;
  logic [H-1:0]         y;
  logic [IW-1:0]        i_end;
  logic [KW-1:0]        k_next;

  function automatic logic [IW-1:0] col_first(input logic [KW-1:0] kk);
    logic [KW-1:0] d;
    d = kk - KW'(NUM_LIMBS - 1);
    if (kk >= KW'(NUM_LIMBS)) begin
      col_first = d[IW-1:0];
    end else begin
      col_first = '0;
    end
  endfunction

  assign tag = qdata[TW-1:0];
  assign idx = qdata[TW+IW-1:TW];
  assign qb  = qdata[TW+IW+LIMB_BITS-1:TW+IW];
  assign qa  = qdata[QW-1:TW+IW+LIMB_BITS];

  assign pop = (state == S_IDLE) && !q_empty;

  // limbs at or above the fill count read as zero
  assign j     = k - KW'(i);
  assign a_ok  = KW'(i) < KW'(fill);
  assign b_ok  = j < KW'(fill);
  assign a_op  = a_ok ? a_mem[i] : '0;
  assign b_op  = b_ok ? b_mem[j[IW-1:0]] : '0;
  assign x     = part[1] ? H'(a_op[LIMB_BITS-1:H]) : a_op[H-1:0];
  assign y     = part[0] ? H'(b_op[LIMB_BITS-1:H]) : b_op[H-1:0];
  assign i_end = (k < KW'(NUM_LIMBS)) ? k[IW-1:0] : IW'(NUM_LIMBS - 1);
  assign k_next = k + KW'(1);

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = AW'(pp);
      2'd1:    pp_ext = AW'(pp) << H;
      2'd2:    pp_ext = AW'(pp) << H;
      2'd3:    pp_ext = AW'(pp) << (2 * H);
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && tag.keep) begin
      a_mem[idx] <= qa;
      b_mem[idx] <= qb;
    end
  end

  always_ff @(posedge clk) begin
    pp    <= (2 * H)'(x) * (2 * H)'(y);
    pp_sh <= part;
    product_limb <= acc[LIMB_BITS-1:0];
    if (state == S_IDLE) begin
      acc <= '0;
    end else if (state == S_EMIT) begin
      acc <= acc >> LIMB_BITS;
    end else if (pp_valid) begin
      acc <= acc + pp_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      pp_valid <= 1'b0;
      strobe   <= 1'b0;
      last_out <= 1'b0;
      k        <= '0;
      i        <= '0;
      part     <= '0;
    end else begin
      pp_valid <= state == S_MUL;
      strobe   <= 1'b0;
      last_out <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (tag.keep) begin
              fill <= CW'(idx) + CW'(1);
            end
            if (tag.last) begin
              state <= S_MUL;
              k     <= '0;
              i     <= '0;
              part  <= '0;
            end
          end
        end
        S_MUL: begin
          part <= part + 2'd1;
          if (part == 2'd3) begin
            if (i == i_end) begin
              state <= S_DRAIN;
            end else begin
              i <= i + IW'(1);
            end
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe   <= 1'b1;
          last_out <= k == TOP;
          if (k == TOP) begin
            state <= S_IDLE;
            fill  <= '0;
          end else begin
            k    <= k_next;
            i    <= col_first(k_next);
            part <= '0;
            // the top column has no limb products, only the carry
            if (k_next != TOP) begin
              state <= S_MUL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/multi_limb_multiply.sv =====
// Schoolbook multiply of two unsigned NUM_LIMBS-limb numbers. Limb pairs are taken
// one per cycle, least significant first, while busy is low; busy goes high only
// when the two-entry item queue in front of the multiplier is full. After the item
// with last_in set, the product is formed column by column with one half-limb
// multiplier, four half-limb partial products per limb product, and 2*NUM_LIMBS
// product limbs come out least significant first, each on product_limb for one
// cycle with strobe high. The receiver cannot stall: every strobe must be taken.
// Pairs past NUM_LIMBS are dropped and missing upper limbs count as zero.
module multi_limb_multiply import mlm_pkg::*; #(
  parameter int NUM_LIMBS = 16,
  parameter int LIMB_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [LIMB_BITS-1:0] a_limb,
  input  logic [LIMB_BITS-1:0] b_limb,
  input  logic                 last_in,
  output logic                 strobe,
  output logic [LIMB_BITS-1:0] product_limb,
  output logic                 last_out
);

  localparam int IW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
  localparam int QW = 2 * LIMB_BITS + IW + $bits(item_tag_t);

  logic          push;
  logic          pop;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  q_status_t     q_stat;

  assign busy = q_stat.full;
  assign push = start && !busy;

  mlm_front #(
    .NUM_LIMBS(NUM_LIMBS),
    .LIMB_BITS(LIMB_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .a_limb (a_limb),
    .b_limb (b_limb),
    .last_in(last_in),
    .qdata  (q_in)
  );

  mlm_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_in),
    .pop   (pop),
    .dout  (q_out),
    .status(q_stat)
  );

  mlm_back #(
    .NUM_LIMBS(NUM_LIMBS),
    .LIMB_BITS(LIMB_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .qdata       (q_out),
    .q_empty     (q_stat.empty),
    .pop         (pop),
    .strobe      (strobe),
    .product_limb(product_limb),
    .last_out    (last_out)
  );

endmodule

// ===== rtl/mlm_checker.sv =====
module mlm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last_out
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("busy or strobe after reset");

  a_busy_needs_item: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  a_gap_after_top: assert property (@(posedge clk) disable iff (rst)
    strobe && last_out |=> !strobe)
    else $error("result right after the top product limb");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last_out |-> strobe)
    else $error("last_out without strobe");

endmodule

bind multi_limb_multiply mlm_checker u_mlm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .strobe  (strobe),
  .last_out(last_out)
);

// ===== dv/multi_limb_multiply_check.sv =====
module multi_limb_multiply_check #(
  parameter int NUM_LIMBS = 16,
  parameter int LIMB_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [LIMB_BITS-1:0] a_limb,
  input  logic [LIMB_BITS-1:0] b_limb,
  input  logic                 last_in,
  input  logic                 strobe,
  input  logic [LIMB_BITS-1:0] product_limb,
  input  logic                 last_out,
  output int                   mismatches,
  output int                   pending
);

  localparam int OP_W   = NUM_LIMBS * LIMB_BITS;
  localparam int PROD_N = 2 * NUM_LIMBS;

  typedef struct packed {
    logic [LIMB_BITS-1:0] limb;
    logic                 last;
  } product_limb_t;

  product_limb_t        expected_limbs[$];
  logic [LIMB_BITS-1:0] a_store[NUM_LIMBS];
  logic [LIMB_BITS-1:0] b_store[NUM_LIMBS];
  int                   limbs_stored;
  int                   bad_count;

  initial begin
    mismatches = 0;
    pending    = 0;
    bad_count  = 0;
  end

  function automatic void clear_operands();
    for (int i = 0; i < NUM_LIMBS; i++) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
    limbs_stored = 0;
  endfunction

  // Full-width product of the stored operands, queued limb by limb.
  function automatic void queue_product();
    logic [2*OP_W-1:0] a_val;
    logic [2*OP_W-1:0] b_val;
    logic [2*OP_W-1:0] prod;
    product_limb_t     e;
    a_val = '0;
    b_val = '0;
    for (int i = 0; i < NUM_LIMBS; i++) begin
      a_val[i*LIMB_BITS +: LIMB_BITS] = a_store[i];
      b_val[i*LIMB_BITS +: LIMB_BITS] = b_store[i];
    end
    prod = a_val * b_val;
    for (int i = 0; i < PROD_N; i++) begin
      e.limb = prod[i*LIMB_BITS +: LIMB_BITS];
      e.last = (i == PROD_N - 1);
      expected_limbs.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    product_limb_t e;
    if (rst) begin
      clear_operands();
      expected_limbs.delete();
    end else begin
      if (strobe) begin
        if (expected_limbs.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected product limb %h last %b", product_limb, last_out);
          bad_count++;
        end else begin
          e = expected_limbs.pop_front();
          if (product_limb !== e.limb || last_out !== e.last) begin
            if (bad_count < 10)
              $display("product limb: expected %h last %b, got %h last %b",
                       e.limb, e.last, product_limb, last_out);
            bad_count++;
          end
        end
      end
      if (start && !busy) begin
        if (limbs_stored < NUM_LIMBS) begin
          a_store[limbs_stored] = a_limb;
          b_store[limbs_stored] = b_limb;
          limbs_stored++;
        end
        if (last_in) begin
          queue_product();
          clear_operands();
        end
      end
    end
    mismatches <= bad_count;
    pending    <= expected_limbs.size();
  end

endmodule

// ===== dv/multi_limb_multiply_tb.sv =====
module multi_limb_multiply_tb;

  localparam int NUM_LIMBS  = 16;
  localparam int LIMB_BITS  = 8;
  localparam int QUIET_MAX  = 20000;
  localparam int TAIL_CYCLES = 1200;
  localparam int ITEM_GOAL  = 210;
  localparam int CALM_FROM  = 175;

  logic                 clk     = 1'b0;
  logic                 rst     = 1'b1;
  logic                 start   = 1'b0;
  logic [LIMB_BITS-1:0] a_limb  = '0;
  logic [LIMB_BITS-1:0] b_limb  = '0;
  logic                 last_in = 1'b0;
  logic                 busy;
  logic                 strobe;
  logic [LIMB_BITS-1:0] product_limb;
  logic                 last_out;
  int                   mismatches;
  int                   pending;
  int                   items_sent;
  int                   quiet_cycles;

  always #5 clk = ~clk;

  multi_limb_multiply #(
    .NUM_LIMBS(NUM_LIMBS),
    .LIMB_BITS(LIMB_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .a_limb(a_limb),
    .b_limb(b_limb),
    .last_in(last_in),
    .strobe(strobe),
    .product_limb(product_limb),
    .last_out(last_out)
  );

  multi_limb_multiply_check #(
    .NUM_LIMBS(NUM_LIMBS),
    .LIMB_BITS(LIMB_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .a_limb(a_limb),
    .b_limb(b_limb),
    .last_in(last_in),
    .strobe(strobe),
    .product_limb(product_limb),
    .last_out(last_out),
    .mismatches(mismatches),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_limbs(input logic [LIMB_BITS-1:0] a, input logic [LIMB_BITS-1:0] b,
                            input logic last, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start   <= 1'b1;
    a_limb  <= a;
    b_limb  <= b;
    last_in <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic logic [LIMB_BITS-1:0] pick_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return LIMB_BITS'('hF0);
      default: return LIMB_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int  len;
    bit  idle_ok;
    quiet_cycles = 0;
    items_sent   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-limb operands
    send_limbs('1, '0, 1'b1, 1'b0);
    // full width, all ones
    for (int i = 0; i < NUM_LIMBS; i++)
      send_limbs('1, '1, i == NUM_LIMBS - 1, 1'b0);
    // short operands, nibble patterns
    send_limbs(LIMB_BITS'('hF0), LIMB_BITS'('h0F), 1'b0, 1'b1);
    send_limbs(LIMB_BITS'('h0F), LIMB_BITS'('hF0), 1'b0, 1'b1);
    send_limbs(LIMB_BITS'('h80), LIMB_BITS'('h01), 1'b1, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: len = NUM_LIMBS;
        1: len = $urandom_range(NUM_LIMBS + 1, NUM_LIMBS + 4);
        2: len = 1;
        default: len = $urandom_range(1, NUM_LIMBS);
      endcase
      idle_ok = ($urandom_range(0, 3) != 0) && (items_sent < CALM_FROM);
      for (int i = 0; i < len; i++)
        send_limbs(pick_limb(), pick_limb(), i == len - 1, idle_ok);
    end
    start   <= 1'b0;
    last_in <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
